### rtl/core/wsg_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator package
// Shared types and constants for the front queue, the back sequencer and the
// sound RAM of the eight-channel wavetable sound generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

    // Bus command codes as they arrive on the input channel.
    localparam logic [1:0] CMD_WR_INDEX = 2'd0;
    localparam logic [1:0] CMD_WR_DATA  = 2'd1;
    localparam logic [1:0] CMD_RD_DATA  = 2'd2;
    localparam logic [1:0] CMD_TICK     = 2'd3;

    localparam int RAM_DEPTH = 128;
    localparam int RAM_AW    = 7;

    localparam logic [3:0] TICKS_PER_SLOT = 4'd15;
    localparam logic [3:0] MID_LEVEL      = 4'd8;
    localparam logic [7:0] LEN_MASK       = 8'hFC;
    localparam logic [8:0] LEN_FULL       = 9'd256;
    localparam logic [2:0] LAST_CHANNEL   = 3'd7;

    // Channel register byte offsets inside a channel's eight-byte block.
    localparam logic [2:0] REG_FREQ_LO   = 3'd0;
    localparam logic [2:0] REG_PHASE_LO  = 3'd1;
    localparam logic [2:0] REG_FREQ_MID  = 3'd2;
    localparam logic [2:0] REG_PHASE_MID = 3'd3;
    localparam logic [2:0] REG_LEN_FREQ  = 3'd4;
    localparam logic [2:0] REG_PHASE_HI  = 3'd5;
    localparam logic [2:0] REG_OFFSET    = 3'd6;
    localparam logic [2:0] REG_VOLUME    = 3'd7;

    typedef enum logic [1:0] {
        OP_WR_INDEX,
        OP_WR_DATA,
        OP_RD_DATA,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [RAM_AW-1:0] raddr;
    } ram_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_FETCH,
        ST_SUM,
        ST_DIV,
        ST_NIB,
        ST_NIB_WAIT,
        ST_WB,
        ST_DONE
    } back_state_t;

endpackage

### rtl/core/wsg_if.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator channels
// Valid/ready interfaces for the bus item channel and the result channel.
// ----------------------------------------------------------------------------
interface wsg_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data;

    modport source (output valid, output cmd, output data, input ready);
    modport sink   (input valid, input cmd, input data, output ready);
endinterface

interface wsg_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] audio_level;
    logic       audio_valid;

    modport source (output valid, output read_data, output audio_level,
                    output audio_valid, input ready);
    modport sink   (input valid, input read_data, input audio_level,
                    input audio_valid, output ready);
endinterface

### rtl/core/wsg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module wsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/wsg_front.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator front end
// Accepts bus beats, classifies the command and holds them in a two-entry
// queue for the back sequencer.
// ----------------------------------------------------------------------------
module wsg_front (
    input  logic            clk,
    input  logic            rst_n,
    wsg_item_if.sink        item,
    output logic            q_valid,
    output wsg_pkg::item_t  q_item,
    input  logic            q_pop
);

    wsg_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    wsg_pkg::item_t push_item;

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        push_item.data = item.data;
        case (item.cmd)
            wsg_pkg::CMD_WR_INDEX: push_item.op = wsg_pkg::OP_WR_INDEX;
            wsg_pkg::CMD_WR_DATA:  push_item.op = wsg_pkg::OP_WR_DATA;
            wsg_pkg::CMD_RD_DATA:  push_item.op = wsg_pkg::OP_RD_DATA;
            default:               push_item.op = wsg_pkg::OP_TICK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/wsg_back.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator back end
// Sequencer that executes queued items against the sound RAM: pointer and
// data access, and the per-tick channel update with nibble fetch and, on the
// first tick of a slot, phase wrap and write-back. Owns the result register.
// ----------------------------------------------------------------------------
module wsg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  wsg_pkg::item_t              q_item,
    output logic                        q_pop,
    output wsg_pkg::ram_req_t           ram_req,
    input  logic [7:0]                  ram_rdata,
    wsg_result_if.source                result
);

    wsg_pkg::back_state_t state_reg;
    wsg_pkg::back_state_t state_next;

    wsg_pkg::op_t         op_reg;
    logic [7:0]           ptr_reg;
    logic [2:0]           chan_reg;
    logic [3:0]           tick_reg;
    logic [3:0]           cnt_reg;
    logic [wsg_pkg::RAM_DEPTH-1:0] vld_reg;
    logic                 rd_vld_reg;
    logic                 cap_reg;
    logic [2:0]           cap_idx_reg;
    logic [7:0]           bytes_reg [8];
    logic [15:0]          sum_reg;
    logic [8:0]           quo_reg;
    logic [7:0]           rem_reg;
    logic [23:0]          phase_reg;
    logic                 nib_hi_reg;
    logic [3:0]           nib_reg;
    logic [7:0]           rdbyte_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_rd_reg;
    logic [3:0]           out_level_reg;
    logic                 out_audio_reg;

    logic [7:0]           rdv;
    logic [8:0]           len;
    logic [8:0]           r_try;
    logic [7:0]           rem_step;
    logic [7:0]           nib_addr;
    logic [3:0]           duty;
    logic [7:0]           ptr_bumped;
    logic                 out_load;
    logic [23:0]          phase_cur;
    logic [24:0]          phase_sum;

    // Entries never written since reset read as zero.
    assign rdv        = rd_vld_reg ? ram_rdata : 8'd0;
    assign len        = wsg_pkg::LEN_FULL - {1'b0, bytes_reg[wsg_pkg::REG_LEN_FREQ]
                                                    & wsg_pkg::LEN_MASK};
    assign r_try      = {rem_reg, quo_reg[8]};
    assign rem_step   = (r_try >= len) ? 8'(r_try - len) : r_try[7:0];
    assign nib_addr   = phase_reg[23:16] + bytes_reg[wsg_pkg::REG_OFFSET];
    assign duty       = ~bytes_reg[wsg_pkg::REG_VOLUME][3:0];
    assign ptr_bumped = ptr_reg[7] ? {1'b1, ptr_reg[6:0] + 7'd1} : ptr_reg;
    assign phase_cur  = {bytes_reg[wsg_pkg::REG_PHASE_HI], bytes_reg[wsg_pkg::REG_PHASE_MID],
                         bytes_reg[wsg_pkg::REG_PHASE_LO]};
    assign phase_sum  = {1'b0, phase_cur}
                      + {7'd0, bytes_reg[wsg_pkg::REG_LEN_FREQ][1:0],
                         bytes_reg[wsg_pkg::REG_FREQ_MID], bytes_reg[wsg_pkg::REG_FREQ_LO]};
    assign out_load   = (state_reg == wsg_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    assign result.valid       = out_valid_reg;
    assign result.read_data   = out_rd_reg;
    assign result.audio_level = out_level_reg;
    assign result.audio_valid = out_audio_reg;

    always_comb
    begin
        state_next    = state_reg;
        q_pop         = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = ptr_reg[6:0];
        ram_req.wdata = q_item.data;
        ram_req.re    = 1'b0;
        ram_req.raddr = ptr_reg[6:0];
        case (state_reg)
            wsg_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        wsg_pkg::OP_WR_INDEX: state_next = wsg_pkg::ST_DONE;
                        wsg_pkg::OP_WR_DATA:
                        begin
                            ram_req.we = 1'b1;
                            state_next = wsg_pkg::ST_DONE;
                        end
                        wsg_pkg::OP_RD_DATA:
                        begin
                            ram_req.re = 1'b1;
                            state_next = wsg_pkg::ST_RD_WAIT;
                        end
                        default:              state_next = wsg_pkg::ST_FETCH;
                    endcase
                end
            end
            wsg_pkg::ST_RD_WAIT: state_next = wsg_pkg::ST_DONE;
            wsg_pkg::ST_FETCH:
            begin
                ram_req.re    = !cnt_reg[3];
                ram_req.raddr = {1'b1, chan_reg, cnt_reg[2:0]};
                if (cnt_reg[3])
                begin
                    state_next = wsg_pkg::ST_SUM;
                end
            end
            wsg_pkg::ST_SUM:
            begin
                state_next = (tick_reg == 4'd0) ? wsg_pkg::ST_DIV : wsg_pkg::ST_NIB;
            end
            wsg_pkg::ST_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = wsg_pkg::ST_NIB;
                end
            end
            wsg_pkg::ST_NIB:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = nib_addr[7:1];
                state_next    = wsg_pkg::ST_NIB_WAIT;
            end
            wsg_pkg::ST_NIB_WAIT:
            begin
                state_next = (tick_reg == 4'd0) ? wsg_pkg::ST_WB : wsg_pkg::ST_DONE;
            end
            wsg_pkg::ST_WB:
            begin
                // The three phase bytes sit at the odd offsets of the block.
                ram_req.we    = 1'b1;
                ram_req.waddr = {1'b1, chan_reg, cnt_reg[1:0], 1'b1};
                case (cnt_reg[1:0])
                    2'd0:    ram_req.wdata = phase_reg[7:0];
                    2'd1:    ram_req.wdata = phase_reg[15:8];
                    default: ram_req.wdata = phase_reg[23:16];
                endcase
                if (cnt_reg[1:0] == 2'd2)
                begin
                    state_next = wsg_pkg::ST_DONE;
                end
            end
            wsg_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = wsg_pkg::ST_IDLE;
                end
            end
            default: state_next = wsg_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsg_pkg::ST_IDLE;
            ptr_reg       <= 8'd0;
            chan_reg      <= 3'd0;
            tick_reg      <= 4'd0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= (state_reg == wsg_pkg::ST_FETCH) && !cnt_reg[3];
            if (ram_req.we)
            begin
                vld_reg[ram_req.waddr] <= 1'b1;
            end
            if (ram_req.re)
            begin
                rd_vld_reg <= vld_reg[ram_req.raddr];
            end
            if (state_reg == wsg_pkg::ST_IDLE && q_valid)
            begin
                if (q_item.op == wsg_pkg::OP_WR_INDEX)
                begin
                    ptr_reg <= q_item.data;
                end
                else if (q_item.op == wsg_pkg::OP_WR_DATA)
                begin
                    ptr_reg <= ptr_bumped;
                end
            end
            if (state_reg == wsg_pkg::ST_RD_WAIT)
            begin
                ptr_reg <= ptr_bumped;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == wsg_pkg::OP_TICK)
                begin
                    if (tick_reg >= wsg_pkg::TICKS_PER_SLOT - 4'd1)
                    begin
                        tick_reg <= 4'd0;
                        // The volume byte of the last channel is RAM byte 0x7F,
                        // which also holds the channel count.
                        if (chan_reg == wsg_pkg::LAST_CHANNEL)
                        begin
                            chan_reg <= ~bytes_reg[wsg_pkg::REG_VOLUME][6:4];
                        end
                        else
                        begin
                            chan_reg <= chan_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        tick_reg <= tick_reg + 4'd1;
                    end
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        cap_idx_reg <= cnt_reg[2:0];
        if (cap_reg)
        begin
            bytes_reg[cap_idx_reg] <= rdv;
        end
        case (state_reg)
            wsg_pkg::ST_IDLE:
            begin
                op_reg  <= q_item.op;
                cnt_reg <= 4'd0;
            end
            wsg_pkg::ST_RD_WAIT: rdbyte_reg <= rdv;
            wsg_pkg::ST_FETCH:   cnt_reg <= cnt_reg + 4'd1;
            wsg_pkg::ST_SUM:
            begin
                sum_reg   <= phase_sum[15:0];
                quo_reg   <= phase_sum[24:16];
                phase_reg <= phase_cur;
                rem_reg   <= 8'd0;
                cnt_reg   <= 4'd8;
            end
            wsg_pkg::ST_DIV:
            begin
                // Restoring remainder of the upper sum bits by the length,
                // one bit per cycle.
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[7:0], 1'b0};
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    phase_reg <= {rem_step, sum_reg};
                end
            end
            wsg_pkg::ST_NIB:     nib_hi_reg <= nib_addr[0];
            wsg_pkg::ST_NIB_WAIT:
            begin
                nib_reg <= nib_hi_reg ? rdv[7:4] : rdv[3:0];
                cnt_reg <= 4'd0;
            end
            wsg_pkg::ST_WB:      cnt_reg <= cnt_reg + 4'd1;
            default:             cnt_reg <= cnt_reg;
        endcase
        if (out_load)
        begin
            out_rd_reg    <= (op_reg == wsg_pkg::OP_RD_DATA) ? rdbyte_reg : 8'd0;
            out_audio_reg <= (op_reg == wsg_pkg::OP_TICK);
            if (op_reg == wsg_pkg::OP_TICK)
            begin
                out_level_reg <= (tick_reg < duty) ? wsg_pkg::MID_LEVEL : nib_reg;
            end
            else
            begin
                out_level_reg <= 4'd0;
            end
        end
    end

endmodule

### rtl/core/wavetable_sound_generator_top.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator
// Eight-channel time-multiplexed wavetable synthesizer with a 128-byte
// sound RAM reached through an index register that auto-increments above 0x7F.
//
// Usage: bus beats enter on the item channel (cmd, data); every beat gives
// exactly one beat on the result channel, in order. Index writes and data
// writes answer with all-zero fields, data reads return the RAM byte, and
// clock ticks return a 4-bit level with audio_valid set.
// A two-entry queue sits behind the item channel, so new beats are taken
// while a finished result waits in the result register.
// The back end handles one item at a time, so it takes no new item until the
// last one's result is loaded. A tick reads eight channel bytes and one wave
// byte through the single read port of the sound RAM; the first tick of a
// slot adds the nine-step phase remainder and three phase write-backs.
// Reset clears the pointer, the slot counters and the per-entry valid bits,
// so the whole sound RAM reads as zero right away; no clearing pass.
// When the receiver stalls, the result holds and the queue fills; the item
// channel drops ready once two beats are waiting.
// ----------------------------------------------------------------------------
module wavetable_sound_generator_top (
    input  logic          clk,
    input  logic          rst_n,
    wsg_item_if.sink      item,
    wsg_result_if.source  result
);

    logic              q_valid;
    wsg_pkg::item_t    q_item;
    logic              q_pop;
    wsg_pkg::ram_req_t ram_req;
    logic [7:0]        ram_rdata;

    wsg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    wsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

    wsg_ram #(
        .WIDTH (8),
        .DEPTH (wsg_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/core/wsg_checker.sv
// ----------------------------------------------------------------------------
// Wavetable sound generator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wsg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] read_data,
    input logic [3:0] audio_level,
    input logic       audio_valid
);

    // Once reset has been seen low at an edge, no result is offered next.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !valid)
        else $error("result valid during reset");

    // A tick result never carries read data.
    a_tick_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        valid && audio_valid |-> read_data == 8'd0)
        else $error("tick result with nonzero read data");

    // Bus results carry a zero level.
    a_bus_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !audio_valid |-> audio_level == 4'd0)
        else $error("bus result with nonzero audio level");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(read_data) && $stable(audio_level)
                            && $stable(audio_valid))
        else $error("stalled result changed");

endmodule

bind wavetable_sound_generator_top wsg_checker u_wsg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .read_data   (result.read_data),
    .audio_level (result.audio_level),
    .audio_valid (result.audio_valid)
);

### test/tb_wavetable_sound_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wavetable sound generator testbench
// Drives bus beats and chip ticks into the generator and predicts every
// result beat from a local copy of the sound RAM, the pointer and the slot
// counters. Directed tests come first. Random traffic follows: register
// bursts, wave fills, reads, tick runs and noise. Both channels idle at
// random, and one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module tb_wavetable_sound_generator_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_BEATS = 500;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] audio_level;
        logic       audio_valid;
    } synth_out_t;

    logic clk;
    logic rst_n;

    wsg_item_if   item_ch ();
    wsg_result_if res_ch ();

    wavetable_sound_generator_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // Local copy of the generator state.
    logic [7:0] snd_ram [wsg_pkg::RAM_DEPTH];
    logic [7:0] snd_ptr;
    logic [2:0] snd_chan;
    logic [3:0] snd_tick;

    synth_out_t pending_outputs [$];
    int         mismatches;
    int         beats_sent;
    int         burst_left;
    int         cycles;
    bit         idle_on;
    bit         hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void bump_ptr();
        if (snd_ptr[7])
            snd_ptr = (snd_ptr + 8'd1) | 8'h80;
    endfunction

    function automatic synth_out_t synth_step(input wsg_pkg::op_t op, input logic [7:0] d);
        synth_out_t  r;
        logic [3:0]  blk;
        logic [31:0] ph;
        logic [31:0] fr;
        logic [31:0] span;
        logic [8:0]  len;
        logic [3:0]  duty;
        logic [7:0]  s;
        logic [7:0]  wbyte;
        logic [3:0]  nib;
        r = '0;
        case (op)
            wsg_pkg::OP_WR_INDEX:
                snd_ptr = d;
            wsg_pkg::OP_WR_DATA:
            begin
                snd_ram[snd_ptr[6:0]] = d;
                bump_ptr();
            end
            wsg_pkg::OP_RD_DATA:
            begin
                r.read_data = snd_ram[snd_ptr[6:0]];
                bump_ptr();
            end
            default:
            begin
                blk  = {1'b1, snd_chan};
                ph   = {8'd0, snd_ram[{blk, wsg_pkg::REG_PHASE_HI}],
                        snd_ram[{blk, wsg_pkg::REG_PHASE_MID}],
                        snd_ram[{blk, wsg_pkg::REG_PHASE_LO}]};
                fr   = {14'd0, snd_ram[{blk, wsg_pkg::REG_LEN_FREQ}][1:0],
                        snd_ram[{blk, wsg_pkg::REG_FREQ_MID}],
                        snd_ram[{blk, wsg_pkg::REG_FREQ_LO}]};
                len  = wsg_pkg::LEN_FULL
                     - {1'b0, snd_ram[{blk, wsg_pkg::REG_LEN_FREQ}] & wsg_pkg::LEN_MASK};
                duty = ~snd_ram[{blk, wsg_pkg::REG_VOLUME}][3:0];
                // The phase is reduced only on the first tick of a slot.
                if (snd_tick == 4'd0)
                begin
                    span = {23'd0, len} << 16;
                    ph   = (ph + fr) % span;
                end
                s     = ph[23:16] + snd_ram[{blk, wsg_pkg::REG_OFFSET}];
                wbyte = snd_ram[s[7:1]];
                nib   = s[0] ? wbyte[7:4] : wbyte[3:0];
                snd_ram[{blk, wsg_pkg::REG_PHASE_HI}]  = ph[23:16];
                snd_ram[{blk, wsg_pkg::REG_PHASE_MID}] = ph[15:8];
                snd_ram[{blk, wsg_pkg::REG_PHASE_LO}]  = ph[7:0];
                r.audio_level = (snd_tick < duty) ? wsg_pkg::MID_LEVEL : nib;
                r.audio_valid = 1'b1;
                if (snd_tick + 4'd1 >= wsg_pkg::TICKS_PER_SLOT)
                begin
                    snd_tick = 4'd0;
                    if (snd_chan >= wsg_pkg::LAST_CHANNEL)
                        snd_chan = 3'((~snd_ram[7'h7F]) >> 4);
                    else
                        snd_chan = snd_chan + 3'd1;
                end
                else
                    snd_tick = snd_tick + 4'd1;
            end
        endcase
        return r;
    endfunction

    // Offers one beat, with a random gap when idling is on and a burst has run out.
    task automatic send_beat(input wsg_pkg::op_t op, input logic [7:0] d);
        int gap;
        if (idle_on && burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.cmd   <= op;
        item_ch.data  <= d;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pending_outputs.push_back(synth_step(op, d));
        beats_sent++;
    endtask

    function automatic logic [7:0] edgy_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 7) == 0)
            v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return v;
    endfunction

    // Result checker: every result beat is matched against the oldest prediction.
    initial
    begin : result_check
        synth_out_t want;
        synth_out_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.read_data, res_ch.audio_level, res_ch.audio_valid};
                if (pending_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with nothing pending: rd=%h lvl=%h av=%b",
                                 got.read_data, got.audio_level, got.audio_valid);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (got.read_data !== want.read_data
                        || got.audio_level !== want.audio_level
                        || got.audio_valid !== want.audio_valid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected rd=%h lvl=%h av=%b, got rd=%h lvl=%h av=%b",
                                     want.read_data, want.audio_level, want.audio_valid,
                                     got.read_data, got.audio_level, got.audio_valid);
                    end
                end
            end
        end
    end

    // Receiver: a rotating ready pattern, reloaded now and then, plus one long hold.
    initial
    begin : result_sink
        logic [15:0] pat;
        int          hold_cnt;
        int          reload_cnt;
        pat        = 16'hFFFF;
        hold_cnt   = 0;
        reload_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
            end
            if (reload_cnt == 0)
            begin
                reload_cnt = $urandom_range(20, 120);
                pat = (!idle_on || $urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                if (pat == 16'h0000)
                    pat = 16'h0001;
            end
            reload_cnt--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= pat[0];
            pat = {pat[0], pat[15:1]};
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Plain pointer, auto-increment and its wrap from the top of the range to 0x80.
    task automatic test_pointer_access();
        send_beat(wsg_pkg::OP_WR_INDEX, 8'h05);
        send_beat(wsg_pkg::OP_WR_DATA, 8'hA5);
        send_beat(wsg_pkg::OP_RD_DATA, 8'($urandom));
        send_beat(wsg_pkg::OP_RD_DATA, 8'($urandom));
        send_beat(wsg_pkg::OP_WR_INDEX, 8'hFE);
        send_beat(wsg_pkg::OP_WR_DATA, 8'h11);
        send_beat(wsg_pkg::OP_WR_DATA, 8'h22);
        send_beat(wsg_pkg::OP_WR_DATA, 8'h33);
        send_beat(wsg_pkg::OP_WR_INDEX, 8'hFF);
        send_beat(wsg_pkg::OP_RD_DATA, 8'($urandom));
        send_beat(wsg_pkg::OP_RD_DATA, 8'($urandom));
    endtask

    // Shortest length, largest frequency, a phase above the length and a
    // middle volume, then a silent channel at full length.
    task automatic test_voice_slot();
        logic [7:0] voice [8] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h0A};
        send_beat(wsg_pkg::OP_WR_INDEX, 8'hC0);
        foreach (voice[k])
            send_beat(wsg_pkg::OP_WR_DATA, voice[k]);
        repeat (int'(wsg_pkg::TICKS_PER_SLOT) + 2)
            send_beat(wsg_pkg::OP_TICK, 8'($urandom));
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                n = $urandom_range(1, 45);
                repeat (n) send_beat(wsg_pkg::OP_TICK, 8'($urandom));
            end
            else if (pick < 55)
            begin
                // Channel register burst, starting anywhere in a block.
                send_beat(wsg_pkg::OP_WR_INDEX, 8'hC0 | 8'($urandom_range(0, 63)));
                n = $urandom_range(1, 8);
                repeat (n) send_beat(wsg_pkg::OP_WR_DATA, edgy_byte());
            end
            else if (pick < 70)
            begin
                send_beat(wsg_pkg::OP_WR_INDEX, 8'h80 | 8'($urandom_range(0, 63)));
                n = $urandom_range(1, 16);
                repeat (n) send_beat(wsg_pkg::OP_WR_DATA, 8'($urandom));
            end
            else if (pick < 85)
            begin
                send_beat(wsg_pkg::OP_WR_INDEX, 8'($urandom));
                n = $urandom_range(1, 4);
                repeat (n) send_beat(wsg_pkg::OP_RD_DATA, 8'($urandom));
            end
            else
                send_beat(wsg_pkg::op_t'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    // The receiver holds off while beats keep coming, so the queue fills.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (20)
        begin
            send_beat(wsg_pkg::OP_WR_INDEX, 8'h80 | 8'($urandom));
            send_beat(wsg_pkg::OP_RD_DATA, 8'($urandom));
            send_beat(wsg_pkg::OP_TICK, 8'($urandom));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(100);
        idle_on = 1'b1;
    endtask

    initial
    begin
        foreach (snd_ram[i])
            snd_ram[i] = 8'h00;
        snd_ptr       = 8'h00;
        snd_chan      = 3'd0;
        snd_tick      = 4'd0;
        mismatches    = 0;
        beats_sent    = 0;
        burst_left    = 0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.cmd   = wsg_pkg::OP_WR_INDEX;
        item_ch.data  = 8'h00;
        res_ch.ready  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pointer_access();
        test_voice_slot();
        test_random_traffic(RANDOM_BEATS);
        test_backpressure();
        test_back_to_back();

        item_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
